### src/plin_pkg.sv
// shared types and constants of the piecewise linear interpolator
`timescale 1ns / 1ps

package plin_pkg;

    // width of one Q16.16 value
    localparam int DATA_W = 32;
    // width of the step counter of one multiply or one divide pass
    localparam int STEP_W = $clog2(DATA_W);

    // command codes
    typedef logic [0:0] t_cmd;
    localparam t_cmd CMD_LOAD  = 1'b0;
    localparam t_cmd CMD_QUERY = 1'b1;

    // result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_INTERP = 2'd0;
    localparam t_status ST_LOW    = 2'd1;
    localparam t_status ST_HIGH   = 2'd2;
    localparam t_status ST_NONE   = 2'd3;

endpackage

### src/piecewise_linear_interpolator_core.sv
// piecewise linear interpolation table, top level with query sequencer
`timescale 1ns / 1ps

// Holds up to MAX_POINTS breakpoint pairs (x, y) in signed Q16.16 and answers
// queries by linear interpolation on the first interval that holds the query,
// clamping to the first or last y outside the table; a query that no
// interval holds gives the no-interval status. A load transfer writes one
// pair and gives no result. A query reads the table one entry per cycle: the
// first entry for a low clamp, then the last for a high clamp (a point count
// of zero goes straight to the result), then the entries from the second on
// up to the interval found, which the shared multiply/divide unit finishes
// (32 shift-add steps, 32 restoring divide steps, the done flag and the
// result). The divide truncates toward zero. The block accepts no new item
// while a query is in progress; a finished result waits in an output
// register while the next item is accepted. The table has no reset and must
// be loaded before it is queried; point_count resets to 2.
module piecewise_linear_interpolator_core
    import plin_pkg::*;
#(
    parameter int MAX_POINTS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [4:0]               i_cfg_data,
    // input item channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_command,
    input  logic [3:0]               i_point_index,
    input  logic signed [DATA_W-1:0] i_point_x,
    input  logic signed [DATA_W-1:0] i_point_y,
    input  logic signed [DATA_W-1:0] i_query_x,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_result_y,
    output logic [1:0]               o_status
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int NW = (CW > 5) ? CW : 5;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FIRST = 6'b000010,
        S_LAST  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_CALC  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state                   r_state, n_state;
    logic [4:0]               r_point_count;
    logic [AW-1:0]            r_addr, n_addr;
    logic [AW-1:0]            r_last, n_last;
    logic                     r_ovalid, n_ovalid;
    logic signed [DATA_W-1:0] r_q, n_q;
    logic signed [DATA_W-1:0] r_px, n_px;
    logic signed [DATA_W-1:0] r_py, n_py;
    logic                     r_neg, n_neg;
    logic signed [DATA_W-1:0] r_res_y, n_res_y;
    t_status                  r_res_st, n_res_st;
    logic signed [DATA_W-1:0] r_out_y;
    t_status                  r_out_st;

    logic                     in_fire;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [2*DATA_W-1:0]      rd_data;
    logic signed [DATA_W-1:0] rd_x;
    logic signed [DATA_W-1:0] rd_y;
    logic [NW-1:0]            cnt_ext;
    logic [NW-1:0]            n_eff;
    logic                     in_interval;
    logic                     y_down;
    logic                     mul_start;
    logic [DATA_W-1:0]        mul_mag;
    logic [DATA_W-1:0]        mul_dq;
    logic [DATA_W-1:0]        mul_dx;
    logic                     md_done;
    logic [DATA_W-1:0]        md_quot;
    logic                     out_load;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid & o_in_ready;

    // breakpoint load, out of range indexes are dropped
    assign ram_we    = in_fire && (i_command == CMD_LOAD)
                       && (32'(i_point_index) < MAX_POINTS);
    assign ram_waddr = AW'(32'(i_point_index));

    plin_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({i_point_x, i_point_y}),
        .i_raddr (n_addr),
        .o_rdata (rd_data)
    );

    assign rd_x = rd_data[2*DATA_W-1:DATA_W];
    assign rd_y = rd_data[DATA_W-1:0];

    // effective point count, limited to the table depth
    assign cnt_ext = NW'(r_point_count);
    assign n_eff   = (cnt_ext > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : cnt_ext;

    // interval test and operands for the multiply/divide unit
    assign in_interval = (r_px <= r_q) && (r_q <= rd_x);
    assign y_down      = (rd_y < r_py);
    assign mul_mag     = y_down ? DATA_W'(r_py - rd_y) : DATA_W'(rd_y - r_py);
    assign mul_dq      = DATA_W'(r_q - r_px);
    assign mul_dx      = DATA_W'(rd_x - r_px);

    plin_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_mag   (mul_mag),
        .i_dq    (mul_dq),
        .i_dx    (mul_dx),
        .o_done  (md_done),
        .o_quot  (md_quot)
    );

    // query sequencer
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_last    = r_last;
        n_q       = r_q;
        n_px      = r_px;
        n_py      = r_py;
        n_neg     = r_neg;
        n_res_y   = r_res_y;
        n_res_st  = r_res_st;
        n_ovalid  = r_ovalid & ~i_out_ready;
        mul_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (i_command == CMD_QUERY)) begin
                    n_q    = i_query_x;
                    n_last = AW'(n_eff - NW'(1));
                    n_addr = '0;
                    if (n_eff == '0) begin
                        n_res_y  = '0;
                        n_res_st = ST_NONE;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                // first entry on the read port
                if (r_q <= rd_x) begin
                    n_res_y  = rd_y;
                    n_res_st = ST_LOW;
                    n_state  = S_OUT;
                end else begin
                    n_px    = rd_x;
                    n_py    = rd_y;
                    n_addr  = r_last;
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                // last entry on the read port
                if (r_q >= rd_x) begin
                    n_res_y  = rd_y;
                    n_res_st = ST_HIGH;
                    n_state  = S_OUT;
                end else begin
                    n_addr  = AW'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // previous entry in registers, current on the read port
                if (in_interval) begin
                    if (r_px == rd_x) begin
                        n_res_y  = r_py;
                        n_res_st = ST_INTERP;
                        n_state  = S_OUT;
                    end else begin
                        mul_start = 1'b1;
                        n_neg     = y_down;
                        n_state   = S_CALC;
                    end
                end else if (r_addr == r_last) begin
                    n_res_y  = '0;
                    n_res_st = ST_NONE;
                    n_state  = S_OUT;
                end else begin
                    n_px   = rd_x;
                    n_py   = rd_y;
                    n_addr = AW'(r_addr + 1'b1);
                end
            end
            S_CALC: begin
                if (md_done) begin
                    n_res_y  = r_neg ? (r_py - signed'(md_quot))
                                     : (r_py + signed'(md_quot));
                    n_res_st = ST_INTERP;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                // hand over once the output register is free
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_point_count <= 5'd2;
            r_addr        <= '0;
            r_last        <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_point_count <= i_cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_q      <= n_q;
        r_px     <= n_px;
        r_py     <= n_py;
        r_neg    <= n_neg;
        r_res_y  <= n_res_y;
        r_res_st <= n_res_st;
        if (out_load) begin
            r_out_y  <= r_res_y;
            r_out_st <= r_res_st;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_result_y  = r_out_y;
    assign o_status    = r_out_st;

endmodule

### src/plin_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module plin_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/plin_muldiv.sv
// iterative shift-add multiply then restoring divide on one shared adder
`timescale 1ns / 1ps

module plin_muldiv
    import plin_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_mag,
    input  logic [DATA_W-1:0] i_dq,
    input  logic [DATA_W-1:0] i_dx,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quot
);

    localparam int OPW = DATA_W + 2;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

    logic              r_busy, n_busy;
    logic              r_div, n_div;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [DATA_W-1:0] r_hi, n_hi;
    logic [DATA_W-1:0] r_lo, n_lo;
    logic [DATA_W-1:0] r_mag;
    logic [DATA_W-1:0] r_dx;

    logic [OPW-1:0] op_a;
    logic [OPW-1:0] op_b;
    logic [OPW-1:0] arith;
    logic           ge;

    // operand select for the shared add/sub
    always_comb begin
        if (r_div) begin
            op_a = {1'b0, r_hi, r_lo[DATA_W-1]};
            op_b = {2'b00, r_dx};
        end else begin
            op_a = {2'b00, r_hi};
            op_b = r_lo[0] ? {2'b00, r_mag} : '0;
        end
    end

    // the shared adder
    assign arith = r_div ? (op_a - op_b) : (op_a + op_b);
    assign ge    = ~arith[OPW-1];

    // step sequencing
    always_comb begin
        n_busy = r_busy;
        n_div  = r_div;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_hi   = r_hi;
        n_lo   = r_lo;
        if (i_start) begin
            n_busy = 1'b1;
            n_div  = 1'b0;
            n_cnt  = '0;
            n_hi   = '0;
            n_lo   = i_dq;
        end else if (r_busy) begin
            n_cnt = STEP_W'(r_cnt + 1'b1);
            if (r_div) begin
                // restoring divide step, quotient bits shift into lo
                n_hi = ge ? arith[DATA_W-1:0] : op_a[DATA_W-1:0];
                n_lo = {r_lo[DATA_W-2:0], ge};
                if (r_cnt == LAST_STEP) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end else begin
                // shift-add multiply step, product ends in {hi, lo}
                n_hi = arith[DATA_W:1];
                n_lo = {arith[0], r_lo[DATA_W-1:1]};
                if (r_cnt == LAST_STEP) begin
                    n_div = 1'b1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_div  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_div  <= n_div;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
        r_lo <= n_lo;
        if (i_start) begin
            r_mag <= i_mag;
            r_dx  <= i_dx;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_lo;

endmodule

### verif/tb_piecewise_linear_interpolator_core.sv
// self-checking testbench of the piecewise linear interpolation table
`timescale 1ns / 1ps

module tb_piecewise_linear_interpolator_core
    import plin_pkg::*;
();

    localparam int TABLE_DEPTH  = 16;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1000000;

    // shapes of the breakpoint tables loaded by the random part
    typedef enum int {
        TBL_WIDE,
        TBL_CLUSTER,
        TBL_SHUFFLED
    } t_table_shape;

    // one expected answer of a query
    typedef struct packed {
        logic signed [DATA_W-1:0] y;
        t_status                  st;
    } t_answer;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [4:0]               i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic                     i_command;
    logic [3:0]               i_point_index;
    logic signed [DATA_W-1:0] i_point_x;
    logic signed [DATA_W-1:0] i_point_y;
    logic signed [DATA_W-1:0] i_query_x;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic signed [DATA_W-1:0] o_result_y;
    logic [1:0]               o_status;

    // predictor state: breakpoint table and point count as the block holds them
    logic signed [DATA_W-1:0] curve_x [TABLE_DEPTH];
    logic signed [DATA_W-1:0] curve_y [TABLE_DEPTH];
    logic [4:0]               table_points = 5'd2;

    t_answer pending_answers [$];
    int      fail_count  = 0;
    int      cycle_count = 0;
    bit      idle_on     = 1'b1;
    bit      hold_req    = 1'b0;

    piecewise_linear_interpolator_core #(
        .MAX_POINTS(TABLE_DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_point_index(i_point_index),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_query_x    (i_query_x),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result_y   (o_result_y),
        .o_status     (o_status)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_piecewise_linear_interpolator_core failed");
            $finish;
        end
    end

    // count a failure, report only the first few
    task automatic log_error(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // expected answer of a query against the current table and point count
    function automatic t_answer interp_expect(input logic signed [DATA_W-1:0] qx);
        t_answer           a;
        int                n;
        int                i;
        longint            q, x0, x1, y0, y1, dy, r;
        longint unsigned   dx, dq, mag, prod;
        bit                neg;
        n    = (table_points > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_points);
        a.y  = '0;
        a.st = ST_NONE;
        if (n == 0) return a;
        q = qx;
        // clamp at either end of the table
        if (q <= longint'(curve_x[0])) begin
            a.y  = curve_y[0];
            a.st = ST_LOW;
            return a;
        end
        if (q >= longint'(curve_x[n-1])) begin
            a.y  = curve_y[n-1];
            a.st = ST_HIGH;
            return a;
        end
        // first interval that holds the query
        for (i = 0; i + 1 < n; i++) begin
            x0 = curve_x[i];
            x1 = curve_x[i+1];
            if (x0 <= q && q <= x1) begin
                y0   = curve_y[i];
                y1   = curve_y[i+1];
                a.st = ST_INTERP;
                if (x1 == x0) begin
                    a.y = y0[DATA_W-1:0];
                    return a;
                end
                dy   = y1 - y0;
                dx   = x1 - x0;
                dq   = q - x0;
                neg  = (dy < 0);
                mag  = neg ? -dy : dy;
                prod = (mag * dq) / dx;
                r    = neg ? (y0 - $signed(prod)) : (y0 + $signed(prod));
                a.y  = r[DATA_W-1:0];
                return a;
            end
        end
        return a;
    endfunction

    // query value: mostly inside the table span, sometimes a breakpoint or noise
    function automatic logic [DATA_W-1:0] pick_query();
        int     n;
        longint lo, hi, q;
        n = (table_points > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_points);
        if (n == 0 || $urandom_range(0, 3) == 0) return $urandom;
        if ($urandom_range(0, 7) == 0) return curve_x[$urandom_range(0, n - 1)];
        lo = curve_x[0];
        hi = curve_x[n-1];
        if (hi <= lo) return $urandom;
        q = lo + (longint'($urandom) % (hi - lo + 1));
        return q[DATA_W-1:0];
    endfunction

    // one input transfer; valid is left high for a following item
    task automatic send_item(input t_cmd cmd, input logic [3:0] idx,
                             input logic [DATA_W-1:0] px, input logic [DATA_W-1:0] py,
                             input logic [DATA_W-1:0] qx);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_point_index <= idx;
        i_point_x     <= px;
        i_point_y     <= py;
        i_query_x     <= qx;
        do @(posedge i_clk); while (!o_in_ready);
        // transfer taken at this edge
        if (cmd == CMD_LOAD) begin
            curve_x[idx] = px;
            curve_y[idx] = py;
        end else begin
            pending_answers.push_back(interp_expect(qx));
        end
    endtask

    // stop sending and wait until every answer is back and the block settles
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // point count write, only with the block idle
    task automatic set_points(input logic [4:0] points);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= points;
        do @(posedge i_clk); while (!o_cfg_ready);
        table_points = points;
        i_cfg_valid <= 1'b0;
    endtask

    // load all entries with a table of the given shape
    task automatic load_table(input t_table_shape shape);
        int xs [$];
        int k;
        for (k = 0; k < TABLE_DEPTH; k++) begin
            if (shape == TBL_CLUSTER) xs.push_back($urandom_range(0, 128) - 64);
            else xs.push_back($urandom);
        end
        if (shape != TBL_SHUFFLED) xs.sort();
        for (k = 0; k < TABLE_DEPTH; k++) begin
            send_item(CMD_LOAD, k[3:0], xs[k], $urandom, $urandom);
        end
    endtask

    // random loads and queries on a fresh table
    task automatic run_random_phase(input logic [4:0] points, input t_table_shape shape,
                                    input int n_items, input bit squeeze);
        set_points(points);
        load_table(shape);
        if (squeeze) hold_req = 1'b1;
        repeat (n_items) begin
            if ($urandom_range(0, 99) < 8) begin
                send_item(CMD_LOAD, 4'($urandom), $urandom, $urandom, $urandom);
            end else begin
                send_item(CMD_QUERY, 4'($urandom), $urandom, $urandom, pick_query());
            end
        end
    endtask

    // two full-range points at the reset count
    task automatic test_reset_count();
        send_item(CMD_LOAD, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_LOAD, 4'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        send_item(CMD_QUERY, 4'hF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000);
        send_item(CMD_QUERY, 4'h0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_item(CMD_QUERY, 4'hA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000);
        send_item(CMD_QUERY, 4'h5, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
        send_item(CMD_QUERY, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
    endtask

    // a single point clamps on both sides
    task automatic test_single_point();
        set_points(5'd1);
        send_item(CMD_QUERY, 4'h3, 32'h0, 32'h0, 32'h8000_0000);
        send_item(CMD_QUERY, 4'hC, 32'h0, 32'h0, 32'h1234_5678);
    endtask

    // empty table gives the no-interval status
    task automatic test_zero_count();
        set_points(5'd0);
        send_item(CMD_QUERY, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    endtask

    // unsorted table: the walk skips a falling interval
    task automatic test_unsorted_walk();
        set_points(5'd4);
        send_item(CMD_LOAD, 4'd0, 32'h0000_0000, 32'h0001_0000, 32'h0);
        send_item(CMD_LOAD, 4'd1, 32'h4000_0000, 32'hFFF0_0000, 32'h0);
        send_item(CMD_LOAD, 4'd2, 32'hF000_0000, 32'h0123_4567, 32'h0);
        send_item(CMD_LOAD, 4'd3, 32'h7000_0000, 32'h8000_0000, 32'h0);
        send_item(CMD_LOAD, 4'd15, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_QUERY, 4'h0, 32'h0, 32'h0, 32'h2000_0000);
        send_item(CMD_QUERY, 4'h0, 32'h0, 32'h0, 32'h5000_0000);
        send_item(CMD_QUERY, 4'h0, 32'h0, 32'h0, 32'h4000_0000);
    endtask

    // random tables at several point counts, the extremes among them
    task automatic test_random_tables();
        run_random_phase(5'd16, TBL_WIDE, 200, 1'b0);
        run_random_phase(5'd2, TBL_CLUSTER, 150, 1'b0);
        run_random_phase(5'd17, TBL_SHUFFLED, 150, 1'b0);
        run_random_phase(5'd1, TBL_WIDE, 100, 1'b0);
        run_random_phase(5'd0, TBL_WIDE, 60, 1'b0);
        run_random_phase(5'd31, TBL_CLUSTER, 150, 1'b0);
        run_random_phase(5'($urandom_range(3, 15)), TBL_WIDE, 150, 1'b0);
        run_random_phase(5'($urandom_range(3, 15)), TBL_CLUSTER, 100, 1'b0);
    endtask

    // result side held off while items keep coming
    task automatic test_output_backpressure();
        run_random_phase(5'd16, TBL_WIDE, 150, 1'b1);
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_steady_stream();
        wait_idle();
        idle_on = 1'b0;
        run_random_phase(5'd16, TBL_SHUFFLED, 200, 1'b0);
    endtask

    // result side: random stalls and one long hold-off on request
    initial begin : result_sink
        int held;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    held++;
                end
                hold_req = 1'b0;
                i_out_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // compare each result transfer with the oldest expected answer
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_answers.size() == 0) begin
                log_error($sformatf("unexpected result y=%h status=%0d",
                                    o_result_y, o_status));
            end else begin
                want = pending_answers.pop_front();
                if (o_result_y !== want.y || o_status !== want.st) begin
                    log_error($sformatf({"result mismatch: expected y=%h status=%0d, ",
                                         "got y=%h status=%0d"},
                                        want.y, want.st, o_result_y, o_status));
                end
            end
        end
    end

    // stimulus sequence
    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_command     <= CMD_LOAD;
        i_point_index <= '0;
        i_point_x     <= '0;
        i_point_y     <= '0;
        i_query_x     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_count();
        test_single_point();
        test_zero_count();
        test_unsorted_walk();
        test_random_tables();
        test_output_backpressure();
        test_steady_stream();

        wait_idle();
        if (pending_answers.size() != 0) begin
            log_error($sformatf("%0d expected results never arrived", pending_answers.size()));
        end
        if (fail_count == 0) begin
            $display("tb_piecewise_linear_interpolator_core passed");
        end else begin
            $display("tb_piecewise_linear_interpolator_core failed");
        end
        $finish;
    end

endmodule
